[hw/rtl/stfi_pkg.sv]
// ----------------------------------------------------------------------------
// stfi_pkg
// Shared types and constants for the sorted-table fractional index block.
// ----------------------------------------------------------------------------
package stfi_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned FRAC_BITS_DEF   = 16;
	localparam int unsigned RADIUS_W        = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[hw/rtl/stfi_item_if.sv]
// ----------------------------------------------------------------------------
// stfi_item_if
// Input channel: table writes and radius queries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stfi_item_if #(
	parameter int unsigned IDX_W = 10
);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [IDX_W-1:0]              entry_index;
	logic [stfi_pkg::RADIUS_W-1:0] entry_value;
	logic [stfi_pkg::RADIUS_W-1:0] query_radius;

	modport source (output valid, opcode, entry_index, entry_value, query_radius, input ready);
	modport sink   (input valid, opcode, entry_index, entry_value, query_radius, output ready);
endinterface

[hw/rtl/stfi_result_if.sv]
// ----------------------------------------------------------------------------
// stfi_result_if
// Output channel: fractional index and clamp flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stfi_result_if #(
	parameter int unsigned FRAC_W = 26
);
	logic              valid;
	logic              ready;
	logic [FRAC_W-1:0] frac_index;
	logic              clamped_low;
	logic              clamped_high;

	modport source (output valid, frac_index, clamped_low, clamped_high, input ready);
	modport sink   (input valid, frac_index, clamped_low, clamped_high, output ready);
endinterface

[hw/rtl/stfi_div.sv]
// ----------------------------------------------------------------------------
// stfi_div
// Bit-serial restoring divider: one quotient bit per cycle.
// Expects rem_init < den, so the quotient fits in FRAC_BITS bits.
// ----------------------------------------------------------------------------
module stfi_div #(
	parameter int unsigned FRAC_BITS = stfi_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [stfi_pkg::RADIUS_W-1:0] rem_init,
	input  logic [stfi_pkg::RADIUS_W-1:0] den,
	output stfi_pkg::div_status_t         status,
	output logic [FRAC_BITS-1:0]          quot
);
	localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
	localparam int unsigned RW    = stfi_pkg::RADIUS_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    den_q;
	logic [FRAC_BITS-1:0] quot_q;

	logic [RW:0] rem_sh;
	logic [RW:0] rem_sub;
	logic        q_bit;

	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_bit   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= q_bit ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], q_bit};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = quot_q;

endmodule

[hw/rtl/sorted_table_fractional_index_top.sv]
// A query holds the block from its transfer until its result enters the output register:
// a low clamp ends once entry 0 is read, a high clamp or a match on the last entry once
// that entry is read, else once the scan reaches the upper index i of the interval found
// (1 .. table_size-1) and the divider is done; an output stall holds it longer. A write
// keeps the block idle. The scan reads one entry and the divider gives one bit per cycle.
// Reset clears control and sets table_size to TABLE_DEPTH; table is undefined until written.
// ----------------------------------------------------------------------------
// sorted_table_fractional_index_top
// Inverse lookup in a table of increasing radii with linear interpolation.
// ----------------------------------------------------------------------------
module sorted_table_fractional_index_top #(
	parameter int unsigned TABLE_DEPTH = stfi_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned FRAC_BITS   = stfi_pkg::FRAC_BITS_DEF,
	localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
	localparam int unsigned CFG_W      = $clog2(TABLE_DEPTH + 1),
	localparam int unsigned FRAC_W     = IDX_W + FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	stfi_item_if.sink              item,
	stfi_result_if.source          result
);
	localparam int unsigned RW = stfi_pkg::RADIUS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] table_size_q;

	// Radius table: one synchronous memory, one write and one read port.
	logic [RW-1:0]    radius_mem_q [TABLE_DEPTH];
	logic [RW-1:0]    rdata_q;
	logic [IDX_W-1:0] rd_addr;

	logic [RW-1:0]    radius_q;  // query radius under work
	logic [RW-1:0]    lo_q;      // lower bound of the current interval
	logic [IDX_W-1:0] idx_q;     // entry index being compared in the scan

	logic [FRAC_W-1:0] res_frac_q;
	logic              res_lo_q;
	logic              res_hi_q;

	logic              out_valid_q;
	logic [FRAC_W-1:0] out_frac_q;
	logic              out_lo_q;
	logic              out_hi_q;

	logic [CFG_W-1:0] eff_size;
	logic [IDX_W-1:0] last_idx;
	logic             item_xfer;
	logic             wr_en;
	logic             scan_go;
	logic             div_start;
	logic [RW-1:0]    div_rem;
	logic [RW-1:0]    div_den;
	logic [FRAC_BITS-1:0] div_quot;
	stfi_pkg::div_status_t div_st;

	// Clamp the configured size into 2 .. TABLE_DEPTH.
	always_comb begin
		if (table_size_q < CFG_W'(2)) begin
			eff_size = CFG_W'(2);
		end else if (table_size_q > CFG_W'(TABLE_DEPTH)) begin
			eff_size = CFG_W'(TABLE_DEPTH);
		end else begin
			eff_size = table_size_q;
		end
	end
	assign last_idx = IDX_W'(eff_size - CFG_W'(1));

	assign item.ready = (state_q == S_IDLE);
	assign item_xfer  = item.valid && item.ready;
	// Drop writes beyond the table.
	assign wr_en = item_xfer && (item.opcode == stfi_pkg::OP_WRITE)
		&& (CFG_W'(item.entry_index) < CFG_W'(TABLE_DEPTH));

	// Keep scanning while below the last entry and the entry is not above the radius.
	assign scan_go = (idx_q != last_idx) && (rdata_q <= radius_q);

	// Read address for the data the next state looks at. Reads and writes never
	// overlap on purpose: writes land only in idle, reads matter only in a query.
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = '0;
			S_FIRST: rd_addr = last_idx;
			S_LAST:  rd_addr = IDX_W'(1);
			S_SCAN:  rd_addr = idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			radius_mem_q[item.entry_index] <= item.entry_value;
		end
		rdata_q <= radius_mem_q[rd_addr];
	end

	// Interval found: fraction = (r - lo) / (hi - lo), with r - lo < hi - lo.
	assign div_start = (state_q == S_SCAN) && !scan_go;
	assign div_rem   = radius_q - lo_q;
	assign div_den   = rdata_q - lo_q;

	stfi_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.rem_init(div_rem),
		.den     (div_den),
		.status  (div_st),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= CFG_W'(TABLE_DEPTH);
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Load the output register from the done state; drop it after the transfer.
			if ((state_q == S_DONE) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// Table 0 read is issued now; it returns in the first state.
					if (item_xfer && (item.opcode == stfi_pkg::OP_QUERY)) begin
						radius_q <= item.query_radius;
						state_q  <= S_FIRST;
					end
				end
				S_FIRST: begin
					lo_q <= rdata_q;
					if (radius_q < rdata_q) begin
						res_frac_q <= '0;
						res_lo_q   <= 1'b1;
						res_hi_q   <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					res_frac_q <= {last_idx, {FRAC_BITS{1'b0}}};
					res_lo_q   <= 1'b0;
					res_hi_q   <= (radius_q > rdata_q);
					if (radius_q >= rdata_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= IDX_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						lo_q  <= rdata_q;
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						res_frac_q <= {idx_q - IDX_W'(1), div_quot};
						res_lo_q   <= 1'b0;
						res_hi_q   <= 1'b0;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || result.ready) begin
						out_frac_q <= res_frac_q;
						out_lo_q   <= res_lo_q;
						out_hi_q   <= res_hi_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frac_index   = out_frac_q;
	assign result.clamped_low  = out_lo_q;
	assign result.clamped_high = out_hi_q;

	// A result never carries both clamp flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.clamped_low && result.clamped_high))
		else $error("both clamp flags set");

	// A low clamp always reports index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clamped_low) |-> (result.frac_index == '0))
		else $error("low clamp with nonzero index");

	// The divider runs only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_st.busy || div_st.done) |-> (state_q == S_DIV))
		else $error("divider active outside divide state");

	// A query transfer blocks the input on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && (item.opcode == stfi_pkg::OP_QUERY)) |=> !item.ready)
		else $error("input ready during a query");

endmodule

[dv/sorted_table_fractional_index_top_tb.sv]
// ----------------------------------------------------------------------------
// sorted_table_fractional_index_top_tb
// Self-checking bench for the radius table lookup. Fills the table through
// write transfers, sends radius queries and checks each fractional index and
// clamp flag against a local model of the table and the interpolation.
// ----------------------------------------------------------------------------
module sorted_table_fractional_index_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = stfi_pkg::TABLE_DEPTH_DEF;
	localparam int unsigned FRAC_BITS   = stfi_pkg::FRAC_BITS_DEF;
	localparam int unsigned RADIUS_W    = stfi_pkg::RADIUS_W;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned CFG_W       = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned FRAC_W      = IDX_W + FRAC_BITS;

	// Cycles to let pass after the last answer before touching the size
	// register; a trailing table write still has to land.
	localparam int unsigned SETTLE_CYCLES = 40;
	// Longest quiet stretch: a full-depth scan plus the divider, plus the
	// longest stall on both sides and the settle time.
	localparam int unsigned QUIET_LIMIT = 8000;
	localparam int unsigned N_PHASES = 10;

	typedef struct packed {
		logic                  opcode;
		logic [IDX_W-1:0]      entry_index;
		logic [RADIUS_W-1:0]   entry_value;
		logic [RADIUS_W-1:0]   query_radius;
	} table_request_t;

	typedef struct packed {
		logic [FRAC_W-1:0] frac;
		logic              clamped_low;
		logic              clamped_high;
	} index_answer_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	stfi_item_if   #(.IDX_W(IDX_W))   item_ch ();
	stfi_result_if #(.FRAC_W(FRAC_W)) res_ch ();

	sorted_table_fractional_index_top #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (res_ch)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Table model: updated at the moment a transfer is accepted, so the
	// expected answer always sees the table exactly as the block sees it.
	// ------------------------------------------------------------------------
	bit [RADIUS_W-1:0] radius_mem [TABLE_DEPTH];
	bit [CFG_W-1:0]    size_model = CFG_W'(TABLE_DEPTH);
	index_answer_t     expected_index_q [$];

	// Stimulus side: requests waiting for the driver, and a planning copy of
	// the table that tracks what has been queued (not yet what was accepted).
	table_request_t    request_q [$];
	bit [RADIUS_W-1:0] plan_mem [TABLE_DEPTH];
	bit                big_table_loaded = 1'b0;

	int unsigned n_issued       = 0;
	int unsigned n_accepted     = 0;
	int unsigned mismatch_count = 0;

	// Idle control: while a steady flag is set that side starts no new idle stretch.
	bit          src_steady = 1'b0;
	bit          snk_steady = 1'b0;
	int unsigned src_gap;
	int unsigned snk_stall;
	int unsigned quiet_cycles;

	int unsigned phase_cfg     [N_PHASES] = '{1024, 1, 3, 2047, 5, 17, 1025, 24, 2, 9};
	int unsigned phase_queries [N_PHASES] = '{16, 8, 8, 6, 8, 10, 6, 10, 8, 8};

	// Sizes outside 2..TABLE_DEPTH are clamped by the block.
	function automatic int unsigned eff_size(input int unsigned cfg);
		if (cfg < 2)
			return 2;
		if (cfg > TABLE_DEPTH)
			return TABLE_DEPTH;
		return cfg;
	endfunction

	// Locate a radius in the table and interpolate inside its interval.
	function automatic index_answer_t locate_radius(input bit [RADIUS_W-1:0] r);
		index_answer_t     ans;
		int unsigned       last;
		int unsigned       i;
		bit [RADIUS_W-1:0] lo_v;
		bit [RADIUS_W-1:0] hi_v;
		bit [63:0]         num;
		bit [63:0]         den;
		bit [63:0]         part;

		ans  = '0;
		last = eff_size(size_model) - 1;
		if (r < radius_mem[0]) begin
			ans.clamped_low = 1'b1;
		end else if (r > radius_mem[last]) begin
			ans.clamped_high = 1'b1;
			ans.frac         = FRAC_W'(64'(last) << FRAC_BITS);
		end else if (r == radius_mem[last]) begin
			ans.frac = FRAC_W'(64'(last) << FRAC_BITS);
		end else begin
			// First entry above the radius, searching from index 1; the one
			// before it is the lower bound. Holds for unsorted tables too.
			i = 1;
			while (i < last && radius_mem[i] <= r)
				i++;
			lo_v = radius_mem[i-1];
			hi_v = radius_mem[i];
			num  = 64'(r - lo_v) << FRAC_BITS;
			den  = 64'(hi_v - lo_v);
			part = (den != 0) ? num / den : 64'd0;
			ans.frac = FRAC_W'((64'(i - 1) << FRAC_BITS) + part);
		end
		return ans;
	endfunction

	// Mostly short idles, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned sel;

		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers. Unused fields of each request carry random junk.
	// ------------------------------------------------------------------------
	task automatic push_write(input int unsigned idx, input bit [RADIUS_W-1:0] val);
		table_request_t req;

		req.opcode       = stfi_pkg::OP_WRITE;
		req.entry_index  = IDX_W'(idx);
		req.entry_value  = val;
		req.query_radius = $urandom;
		request_q.push_back(req);
		plan_mem[idx] = val;
		n_issued++;
	endtask

	task automatic push_query(input bit [RADIUS_W-1:0] r);
		table_request_t req;

		req.opcode       = stfi_pkg::OP_QUERY;
		req.entry_index  = IDX_W'($urandom);
		req.entry_value  = $urandom;
		req.query_radius = r;
		request_q.push_back(req);
		n_issued++;
	endtask

	// Fill entries 0..n-1 with a rising sequence; a few equal neighbors slip in.
	task automatic fill_table(input int unsigned n);
		bit [RADIUS_W-1:0] v;
		bit [RADIUS_W-1:0] step;
		bit [RADIUS_W-1:0] step_max;
		int unsigned       sel;

		v        = ($urandom_range(0, 9) < 3) ? 32'd0 : $urandom_range(0, 32'h0100_0000);
		step_max = (32'hFFFF_FFFF - v) / n;
		for (int unsigned k = 0; k < n; k++) begin
			push_write(k, v);
			sel = $urandom_range(0, 99);
			if (sel < 5)
				step = 0;
			else if (sel < 15)
				step = 1;
			else if (sel < 70)
				step = $urandom_range(1, (step_max < 32'h4_0000) ? step_max : 32'h4_0000);
			else
				step = $urandom_range(1, step_max);
			v += step;
		end
	endtask

	// Choose a radius against the planned table: mostly inside an interval,
	// the rest on entries, beyond either end, or anywhere.
	task automatic pick_query(input int unsigned n);
		int unsigned       last;
		int unsigned       sel;
		int unsigned       k;
		bit [RADIUS_W-1:0] lo_v;
		bit [RADIUS_W-1:0] hi_v;
		bit [RADIUS_W-1:0] r;

		last = n - 1;
		sel  = $urandom_range(0, 99);
		if (sel < 8) begin
			r = $urandom;
		end else if (sel < 15) begin
			r = (plan_mem[0] != 0) ? $urandom_range(0, plan_mem[0] - 1) : 32'd0;
		end else if (sel < 22) begin
			r = (plan_mem[last] != 32'hFFFF_FFFF) ?
				$urandom_range(plan_mem[last] + 1, 32'hFFFF_FFFF) : 32'hFFFF_FFFF;
		end else if (sel < 35) begin
			r = plan_mem[$urandom_range(0, last)];
		end else begin
			k    = $urandom_range(0, last - 1);
			lo_v = plan_mem[k];
			hi_v = plan_mem[k+1];
			r    = (hi_v > lo_v + 1) ? $urandom_range(lo_v, hi_v - 1) : lo_v;
		end
		push_query(r);
	endtask

	// Hold until every request is accepted and answered, then let the block
	// drain a trailing write.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (n_accepted != n_issued || expected_index_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_table_size(input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(val);
		size_model = CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the next request, hold it until the transfer, and feed
	// every accepted transfer into the table model.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_requests
		table_request_t req;

		if (!arst_n) begin
			item_ch.valid        <= 1'b0;
			item_ch.opcode       <= stfi_pkg::OP_WRITE;
			item_ch.entry_index  <= '0;
			item_ch.entry_value  <= '0;
			item_ch.query_radius <= '0;
			src_gap              <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				n_accepted++;
				// A 10-bit index never exceeds this table depth.
				if (item_ch.opcode == stfi_pkg::OP_WRITE)
					radius_mem[item_ch.entry_index] = item_ch.entry_value;
				else
					expected_index_q.push_back(locate_radius(item_ch.query_radius));
			end
			// Advance only when nothing is held waiting for ready.
			if (!item_ch.valid || item_ch.ready) begin
				if (src_gap != 0) begin
					item_ch.valid <= 1'b0;
					src_gap       <= src_gap - 1;
				end else if (request_q.size() != 0) begin
					req = request_q.pop_front();
					item_ch.valid        <= 1'b1;
					item_ch.opcode       <= req.opcode;
					item_ch.entry_index  <= req.entry_index;
					item_ch.entry_value  <= req.entry_value;
					item_ch.query_radius <= req.query_radius;
					src_gap              <= src_steady ? 0 : pick_gap();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: stall the result side at random and check each transfer
	// against the oldest expected answer.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : check_answers
		index_answer_t want;

		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_stall    <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_index_q.size() == 0) begin
					$display("%0t: result with no query pending: frac_index %h low %b high %b",
						$time, res_ch.frac_index, res_ch.clamped_low, res_ch.clamped_high);
					mismatch_count++;
				end else begin
					want = expected_index_q.pop_front();
					if (res_ch.frac_index !== want.frac) begin
						$display("%0t: frac_index expected %h actual %h",
							$time, want.frac, res_ch.frac_index);
						mismatch_count++;
					end
					if (res_ch.clamped_low !== want.clamped_low) begin
						$display("%0t: clamped_low expected %b actual %b",
							$time, want.clamped_low, res_ch.clamped_low);
						mismatch_count++;
					end
					if (res_ch.clamped_high !== want.clamped_high) begin
						$display("%0t: clamped_high expected %b actual %b",
							$time, want.clamped_high, res_ch.clamped_high);
						mismatch_count++;
					end
				end
			end
			if (snk_stall != 0) begin
				res_ch.ready <= 1'b0;
				snk_stall    <= snk_stall - 1;
			end else if (!snk_steady && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				snk_stall    <= pick_gap();
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Flip each side between idling and steady stretches now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			src_steady <= ~src_steady;
		if ($urandom_range(0, 299) == 0)
			snk_steady <= ~snk_steady;
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sorted_table_fractional_index_top_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned n;

		// Hold reset and keep the size port quiet; the channels reset in
		// their own blocks.
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on a two-entry table (a size of 0 acts as 2).
		write_table_size(0);
		push_write(0, 32'h0001_0000);
		push_write(1, 32'h0003_0000);
		push_query(32'h0000_0000);     // below the first entry
		push_query(32'h0000_FFFF);     // just below the first entry
		push_query(32'h0001_0000);     // on the first entry: zero index
		push_query(32'h0001_8000);     // quarter of the way up
		push_query(32'h0002_FFFF);     // fraction just under one
		push_query(32'h0003_0000);     // equal to the last entry
		push_query(32'h0003_0001);     // just above the last entry
		push_query(32'hFFFF_FFFF);     // far above
		// Full span of the radius range.
		push_write(0, 32'h0000_0000);
		push_write(1, 32'hFFFF_FFFF);
		push_query(32'h0000_0000);
		push_query(32'h8000_0000);
		push_query(32'hFFFF_FFFE);
		push_query(32'hFFFF_FFFF);
		// Equal entries, then a falling table.
		push_write(1, 32'h0000_0000);
		push_query(32'h0000_0000);
		push_query(32'h0000_0001);
		push_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF);
		push_write(0, 32'd5);
		push_write(1, 32'd3);
		push_query(32'd4);
		push_query(32'd5);
		wait_idle();

		// Random phases: one size setting each, table refilled where needed,
		// queries with an occasional stray write that breaks the ordering.
		for (int unsigned p = 0; p < N_PHASES; p++) begin
			write_table_size(phase_cfg[p]);
			n = eff_size(phase_cfg[p]);
			if (n < TABLE_DEPTH || !big_table_loaded) begin
				fill_table(n);
				if (n == TABLE_DEPTH)
					big_table_loaded = 1'b1;
			end
			for (int unsigned q = 0; q < phase_queries[p]; q++) begin
				if ($urandom_range(0, 99) < 7)
					push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
				pick_query(n);
			end
			wait_idle();
		end

		if (mismatch_count == 0 && expected_index_q.size() == 0)
			$display("sorted_table_fractional_index_top_tb: clean");
		else
			$display("sorted_table_fractional_index_top_tb: errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/stfi_pkg.sv
hw/rtl/stfi_item_if.sv
hw/rtl/stfi_result_if.sv
hw/rtl/stfi_div.sv
hw/rtl/sorted_table_fractional_index_top.sv
dv/sorted_table_fractional_index_top_tb.sv
